// ===== design/lpr_pkg.sv =====
// Package for the longest prefix route lookup block.
// Holds table sizes, field widths, opcodes and the table entry type.
// Depends on nothing.
package lpr_pkg;

    localparam int ROUTE_ENTRIES = 64;
    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 4;
    localparam int SLOT_W = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } route_entry_t;

endpackage

// ===== design/longest_prefix_route_lookup_top.sv =====
// Top level of the longest prefix route lookup block.
// Holds the route table memory, the valid bits and the scan sequencer.
// Depends on lpr_pkg.
//
// Usage:
// The input channel (in_valid, in_stall and the entry and lookup fields)
// carries one word per item. A write word (opcode write) stores or removes
// one table slot and gives no result. A lookup word starts a scan that
// reads the 64-slot route memory one slot per cycle through its single
// read port and then loads the best match into the result register.
// The input is stalled for the whole scan and taken again afterward.
// The output channel (out_valid, out_stall and the match fields) presents
// one result word per lookup from an output register. While the receiver
// stalls, the word holds and new writes are still taken; a finished lookup
// waits for the register to drain before it is delivered.
// Reset clears all valid bits, so the table starts empty; no clearing pass
// is needed and the block takes words in the first cycle after reset.
module longest_prefix_route_lookup_top
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [lpr_pkg::SLOT_W-1:0]  entry_index,
    input  logic                        entry_valid,
    input  logic [lpr_pkg::ADDR_W-1:0]  entry_dest,
    input  logic [lpr_pkg::ADDR_W-1:0]  entry_mask,
    input  logic [lpr_pkg::ADDR_W-1:0]  entry_gateway,
    input  logic [lpr_pkg::PORT_W-1:0]  entry_port,
    input  logic [lpr_pkg::ADDR_W-1:0]  lookup_addr,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hit,
    output logic [lpr_pkg::SLOT_W-1:0]  match_index,
    output logic [lpr_pkg::ADDR_W-1:0]  match_gateway,
    output logic [lpr_pkg::PORT_W-1:0]  match_port,
    output logic [lpr_pkg::ADDR_W-1:0]  match_mask
);

    localparam int N = lpr_pkg::ROUTE_ENTRIES;
    localparam int IW = lpr_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    lpr_pkg::route_entry_t route_mem [N];
    lpr_pkg::route_entry_t rd_data_reg;
    lpr_pkg::route_entry_t wr_data;
    logic                  mem_we;
    logic [IW-1:0]         wr_idx;
    logic                  in_range;

    state_t                     state_reg, state_next;
    logic [N-1:0]               valid_bits_reg, valid_bits_next;
    logic [lpr_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [IW-1:0]              rd_cnt_reg, rd_cnt_next;
    logic                       issue_done_reg, issue_done_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                       found_reg, found_next;
    logic [IW-1:0]              best_idx_reg, best_idx_next;
    logic [lpr_pkg::ADDR_W-1:0] best_mask_reg, best_mask_next;
    logic [lpr_pkg::ADDR_W-1:0] best_gw_reg, best_gw_next;
    logic [lpr_pkg::PORT_W-1:0] best_port_reg, best_port_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       hit_reg, hit_next;
    logic [lpr_pkg::SLOT_W-1:0] match_index_reg, match_index_next;
    logic [lpr_pkg::ADDR_W-1:0] match_gateway_reg, match_gateway_next;
    logic [lpr_pkg::PORT_W-1:0] match_port_reg, match_port_next;
    logic [lpr_pkg::ADDR_W-1:0] match_mask_reg, match_mask_next;

    logic                       entry_match;
    logic                       take_entry;

    assign wr_idx = IW'(entry_index);
    assign in_range = (32'(entry_index) < 32'(N));
    assign wr_data = '{dest: entry_dest, mask: entry_mask,
                       gateway: entry_gateway, port: entry_port};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            route_mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= route_mem[rd_cnt_reg];
    end

    assign entry_match = valid_bits_reg[cmp_idx_reg]
                         && (((addr_reg ^ rd_data_reg.dest) & rd_data_reg.mask) == '0);
    assign take_entry = cmp_vld_reg && entry_match
                        && (!found_reg || (rd_data_reg.mask > best_mask_reg));

    always_comb
    begin
        state_next = state_reg;
        valid_bits_next = valid_bits_reg;
        addr_next = addr_reg;
        rd_cnt_next = rd_cnt_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        found_next = found_reg;
        best_idx_next = best_idx_reg;
        best_mask_next = best_mask_reg;
        best_gw_next = best_gw_reg;
        best_port_next = best_port_reg;
        out_valid_next = out_valid_reg;
        hit_next = hit_reg;
        match_index_next = match_index_reg;
        match_gateway_next = match_gateway_reg;
        match_port_next = match_port_reg;
        match_mask_next = match_mask_reg;
        mem_we = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == lpr_pkg::OP_WRITE)
                    begin
                        if (in_range)
                        begin
                            mem_we = entry_valid;
                            valid_bits_next[wr_idx] = entry_valid;
                        end
                    end
                    else
                    begin
                        addr_next = lookup_addr;
                        rd_cnt_next = '0;
                        issue_done_next = 1'b0;
                        cmp_vld_next = 1'b0;
                        found_next = 1'b0;
                        best_mask_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_cnt_reg;
                    if (rd_cnt_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + IW'(1);
                    end
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
                if (take_entry)
                begin
                    found_next = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_mask_next = rd_data_reg.mask;
                    best_gw_next = rd_data_reg.gateway;
                    best_port_next = rd_data_reg.port;
                end
                if (issue_done_reg && cmp_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next = found_reg;
                    if (found_reg)
                    begin
                        match_index_next = lpr_pkg::SLOT_W'(32'(best_idx_reg));
                        match_gateway_next = best_gw_reg;
                        match_port_next = best_port_reg;
                        match_mask_next = best_mask_reg;
                    end
                    else
                    begin
                        match_index_next = '0;
                        match_gateway_next = '0;
                        match_port_next = '0;
                        match_mask_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_bits_reg <= '0;
            rd_cnt_reg <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_bits_reg <= valid_bits_next;
            rd_cnt_reg <= rd_cnt_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        cmp_idx_reg <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_mask_reg <= best_mask_next;
        best_gw_reg <= best_gw_next;
        best_port_reg <= best_port_next;
        hit_reg <= hit_next;
        match_index_reg <= match_index_next;
        match_gateway_reg <= match_gateway_next;
        match_port_reg <= match_port_next;
        match_mask_reg <= match_mask_next;
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign match_index = match_index_reg;
    assign match_gateway = match_gateway_reg;
    assign match_port = match_port_reg;
    assign match_mask = match_mask_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for longest_prefix_route_lookup_top: directed and random
// route writes and lookups, with results predicted from a local copy of the table.
// Depends on lpr_pkg and the longest_prefix_route_lookup_top RTL.
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 2 * lpr_pkg::ROUTE_ENTRIES + 20;
    localparam int RANDOM_WORDS = 342;

    typedef struct packed {
        logic                       hit;
        logic [lpr_pkg::SLOT_W-1:0] index;
        logic [lpr_pkg::ADDR_W-1:0] gateway;
        logic [lpr_pkg::PORT_W-1:0] port;
        logic [lpr_pkg::ADDR_W-1:0] mask;
    } route_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                       in_valid;
    logic                       in_stall;
    logic                       opcode;
    logic [lpr_pkg::SLOT_W-1:0] entry_index;
    logic                       entry_valid;
    logic [lpr_pkg::ADDR_W-1:0] entry_dest;
    logic [lpr_pkg::ADDR_W-1:0] entry_mask;
    logic [lpr_pkg::ADDR_W-1:0] entry_gateway;
    logic [lpr_pkg::PORT_W-1:0] entry_port;
    logic [lpr_pkg::ADDR_W-1:0] lookup_addr;

    logic                       out_valid;
    logic                       out_stall;
    logic                       hit;
    logic [lpr_pkg::SLOT_W-1:0] match_index;
    logic [lpr_pkg::ADDR_W-1:0] match_gateway;
    logic [lpr_pkg::PORT_W-1:0] match_port;
    logic [lpr_pkg::ADDR_W-1:0] match_mask;

    lpr_pkg::route_entry_t route_tbl [lpr_pkg::ROUTE_ENTRIES];
    logic                  route_live [lpr_pkg::ROUTE_ENTRIES];
    route_result_t         route_expect_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int quiet_cycles;

    longest_prefix_route_lookup_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .entry_index   (entry_index),
        .entry_valid   (entry_valid),
        .entry_dest    (entry_dest),
        .entry_mask    (entry_mask),
        .entry_gateway (entry_gateway),
        .entry_port    (entry_port),
        .lookup_addr   (lookup_addr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .match_index   (match_index),
        .match_gateway (match_gateway),
        .match_port    (match_port),
        .match_mask    (match_mask)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [lpr_pkg::ADDR_W-1:0] prefix_mask(input int len);
        return (len == 0) ? '0
                          : ({lpr_pkg::ADDR_W{1'b1}} << (lpr_pkg::ADDR_W - len));
    endfunction

    function automatic route_result_t predict_route(input logic [lpr_pkg::ADDR_W-1:0] addr);
        route_result_t best;
        logic [lpr_pkg::ADDR_W-1:0] m;
        best = '0;
        for (int i = 0; i < lpr_pkg::ROUTE_ENTRIES; i++)
        begin
            if (route_live[i])
            begin
                m = route_tbl[i].mask;
                if ((addr & m) == (route_tbl[i].dest & m) && (!best.hit || m > best.mask))
                begin
                    best.hit = 1'b1;
                    best.index = lpr_pkg::SLOT_W'(i);
                    best.gateway = route_tbl[i].gateway;
                    best.port = route_tbl[i].port;
                    best.mask = m;
                end
            end
        end
        return best;
    endfunction

    function automatic int pick_live_slot();
        int live [$];
        for (int i = 0; i < lpr_pkg::ROUTE_ENTRIES; i++)
        begin
            if (route_live[i])
            begin
                live.push_back(i);
            end
        end
        if (live.size() == 0)
        begin
            return -1;
        end
        return live[$urandom_range(live.size() - 1)];
    endfunction

    task automatic report_mismatch(input string what, input logic [lpr_pkg::ADDR_W-1:0] got,
                                   input logic [lpr_pkg::ADDR_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_word(input logic op, input logic [lpr_pkg::SLOT_W-1:0] idx,
                             input logic vld, input logic [lpr_pkg::ADDR_W-1:0] dest,
                             input logic [lpr_pkg::ADDR_W-1:0] mask,
                             input logic [lpr_pkg::ADDR_W-1:0] gw,
                             input logic [lpr_pkg::PORT_W-1:0] prt,
                             input logic [lpr_pkg::ADDR_W-1:0] addr);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        entry_index <= idx;
        entry_valid <= vld;
        entry_dest <= dest;
        entry_mask <= mask;
        entry_gateway <= gw;
        entry_port <= prt;
        lookup_addr <= addr;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (op == lpr_pkg::OP_WRITE)
        begin
            if (vld)
            begin
                route_tbl[idx].dest = dest;
                route_tbl[idx].mask = mask;
                route_tbl[idx].gateway = gw;
                route_tbl[idx].port = prt;
            end
            route_live[idx] = vld;
        end
        else
        begin
            route_expect_q.push_back(predict_route(addr));
        end
    endtask

    task automatic write_route(input int idx, input logic vld,
                               input logic [lpr_pkg::ADDR_W-1:0] dest,
                               input logic [lpr_pkg::ADDR_W-1:0] mask,
                               input logic [lpr_pkg::ADDR_W-1:0] gw, input int prt);
        send_word(lpr_pkg::OP_WRITE, lpr_pkg::SLOT_W'(idx), vld, dest, mask, gw,
                  lpr_pkg::PORT_W'(prt), $urandom());
    endtask

    task automatic lookup_route(input logic [lpr_pkg::ADDR_W-1:0] addr);
        send_word(lpr_pkg::OP_LOOKUP, lpr_pkg::SLOT_W'($urandom()), 1'($urandom()),
                  $urandom(), $urandom(), $urandom(), lpr_pkg::PORT_W'($urandom()), addr);
    endtask

    task automatic test_empty_table();
        lookup_route(32'h0000_0000);
        lookup_route(32'hFFFF_FFFF);
    endtask

    task automatic test_default_route();
        write_route(63, 1'b1, $urandom(), 32'h0000_0000, 32'hFFFF_FFFF, 15);
        lookup_route($urandom());
    endtask

    task automatic test_longest_prefix();
        write_route(10, 1'b1, 32'h0A00_0000, prefix_mask(8), 32'h0A00_0001, 1);
        write_route(5, 1'b1, 32'h0A01_0000, prefix_mask(16), 32'h0A01_0001, 2);
        write_route(0, 1'b1, 32'h0A01_0200, prefix_mask(24), 32'h0000_0000, 0);
        write_route(20, 1'b1, 32'h0A01_0203, prefix_mask(32), 32'h0A01_02FE, 7);
        lookup_route(32'h0A01_0203);
        lookup_route(32'h0A01_0204);
        lookup_route(32'h0A01_0909);
        lookup_route(32'h0AC8_0001);
        lookup_route(32'h0B00_0000);
    endtask

    task automatic test_equal_masks();
        write_route(40, 1'b1, 32'hC0A8_0000, prefix_mask(16), 32'hC0A8_0028, 4);
        write_route(30, 1'b1, 32'hC0A8_0000, prefix_mask(16), 32'hC0A8_001E, 3);
        lookup_route(32'hC0A8_0505);
    endtask

    task automatic test_entry_removal();
        write_route(30, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15);
        lookup_route(32'hC0A8_0505);
        write_route(63, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
        lookup_route(32'h0B00_0000);
        write_route(30, 1'b1, 32'hC0A8_0000, prefix_mask(16), 32'hC0A8_0031, 9);
        lookup_route(32'hC0A8_FFFF);
    endtask

    task automatic test_field_extremes();
        write_route(1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15);
        lookup_route(32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(input int n_words);
        int kind;
        int slot;
        int plen;
        logic [lpr_pkg::ADDR_W-1:0] base;
        logic [lpr_pkg::ADDR_W-1:0] msk;
        logic [lpr_pkg::ADDR_W-1:0] dest;
        for (int n = 0; n < n_words; n++)
        begin
            kind = $urandom_range(99);
            slot = pick_live_slot();
            if (kind < 32)
            begin
                plen = $urandom_range(lpr_pkg::ADDR_W);
                base = (slot >= 0 && $urandom_range(1) == 1) ? route_tbl[slot].dest
                                                             : $urandom();
                dest = (base & prefix_mask(plen)) | ($urandom() & ~prefix_mask(plen));
                msk = ($urandom_range(19) == 0) ? $urandom() : prefix_mask(plen);
                write_route($urandom_range(lpr_pkg::ROUTE_ENTRIES - 1), 1'b1, dest, msk,
                            $urandom(), $urandom_range(15));
            end
            else if (kind < 40)
            begin
                if (slot < 0 || $urandom_range(9) < 4)
                begin
                    slot = $urandom_range(lpr_pkg::ROUTE_ENTRIES - 1);
                end
                write_route(slot, 1'b0, $urandom(), $urandom(), $urandom(),
                            $urandom_range(15));
            end
            else if (kind < 85 && slot >= 0)
            begin
                msk = route_tbl[slot].mask;
                lookup_route((route_tbl[slot].dest & msk) | ($urandom() & ~msk));
            end
            else
            begin
                lookup_route($urandom());
            end
        end
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        route_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (route_expect_q.size() == 0)
            begin
                report_mismatch("unexpected result word", match_gateway, '0);
            end
            else
            begin
                want = route_expect_q.pop_front();
                if (hit !== want.hit)
                begin
                    report_mismatch("hit", lpr_pkg::ADDR_W'(hit), lpr_pkg::ADDR_W'(want.hit));
                end
                if (match_index !== want.index)
                begin
                    report_mismatch("match_index", lpr_pkg::ADDR_W'(match_index),
                                    lpr_pkg::ADDR_W'(want.index));
                end
                if (match_gateway !== want.gateway)
                begin
                    report_mismatch("match_gateway", match_gateway, want.gateway);
                end
                if (match_port !== want.port)
                begin
                    report_mismatch("match_port", lpr_pkg::ADDR_W'(match_port),
                                    lpr_pkg::ADDR_W'(want.port));
                end
                if (match_mask !== want.mask)
                begin
                    report_mismatch("match_mask", match_mask, want.mask);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** longest_prefix_route_lookup_top: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = lpr_pkg::OP_WRITE;
        entry_index = '0;
        entry_valid = 1'b0;
        entry_dest = '0;
        entry_mask = '0;
        entry_gateway = '0;
        entry_port = '0;
        lookup_addr = '0;
        send_idle_pct = 27;
        recv_idle_pct = 49;
        for (int i = 0; i < lpr_pkg::ROUTE_ENTRIES; i++)
        begin
            route_live[i] = 1'b0;
            route_tbl[i] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_default_route();
        test_longest_prefix();
        test_equal_masks();
        test_entry_removal();
        test_field_extremes();

        test_random_traffic(RANDOM_WORDS);
        send_idle_pct = 49;
        recv_idle_pct = 27;
        test_random_traffic(RANDOM_WORDS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_WORDS);

        @(negedge clk);
        in_valid <= 1'b0;
        while (route_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("** longest_prefix_route_lookup_top: PASSED **");
        end
        else
        begin
            $display("** longest_prefix_route_lookup_top: FAILED **");
        end
        $finish;
    end

endmodule
